FILE: rtl/bafl_pkg.sv
// Shared types and constants for the block-average FIR low-pass core.
package bafl_pkg;

  localparam int unsigned NumCoef    = 5;
  localparam int unsigned CoefW      = 13;
  localparam int unsigned PresW      = 12;
  localparam int unsigned TempW      = 16;
  localparam int unsigned NumChan    = 5;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [CoefW-1:0] CoefReset [NumCoef] = '{
    13'd2457, 13'd819, 13'd409, 13'd286, 13'd122
  };

  typedef enum logic [0:0] {
    ReqSample = 1'b0,
    ReqTick   = 1'b1
  } req_type_e;

  typedef struct packed {
    logic                    req_type;
    logic [PresW-1:0]        pressure_a;
    logic [PresW-1:0]        pressure_b;
    logic signed [TempW-1:0] temp_a;
    logic signed [TempW-1:0] temp_b;
    logic signed [TempW-1:0] temp_c;
    logic                    valid_a;
    logic                    valid_b;
    logic                    valid_c;
  } req_t;

  typedef struct packed {
    logic [PresW-1:0]        filt_pressure_a;
    logic [PresW-1:0]        filt_pressure_b;
    logic signed [TempW-1:0] filt_temp_a;
    logic signed [TempW-1:0] filt_temp_b;
    logic signed [TempW-1:0] filt_temp_c;
  } rsp_t;

endpackage

FILE: rtl/bafl_req_if.sv
// Valid/ready channel interfaces for requests and responses.
interface bafl_req_if
  import bafl_pkg::*;
();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bafl_rsp_if
  import bafl_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/bafl_front.sv
// Front end: accumulates samples and queues period totals on each tick.
module bafl_front
  import bafl_pkg::*;
#(
  parameter int unsigned MaxSamples = 256,
  parameter int unsigned CntW       = 9,
  parameter int unsigned PSumW      = 20,
  parameter int unsigned TSumW      = 25
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  req_t                     in_data_i,
  output logic                     tot_valid_o,
  input  logic                     tot_ready_i,
  output logic [PSumW-1:0]         psum_o [2],
  output logic [CntW-1:0]          pcnt_o,
  output logic signed [TSumW-1:0]  tsum_o [3],
  output logic [CntW-1:0]          tcnt_o [3]
);

  logic [PSumW-1:0]        psum_q [2];
  logic [CntW-1:0]         pcnt_q;
  logic signed [TSumW-1:0] tsum_q [3];
  logic [CntW-1:0]         tcnt_q [3];
  logic                    full_q;
  logic                    acc_ok;
  logic                    tick;
  logic [2:0]              tv;
  logic signed [TempW-1:0] tin [3];

  assign tick       = in_data_i.req_type == ReqTick;
  assign in_ready_o = !tick || !full_q;
  assign acc_ok     = in_valid_i && in_ready_o && !tick &&
                      (32'(pcnt_q) < MaxSamples);
  assign tv         = {in_data_i.valid_c, in_data_i.valid_b, in_data_i.valid_a};
  assign tin[0]     = in_data_i.temp_a;
  assign tin[1]     = in_data_i.temp_b;
  assign tin[2]     = in_data_i.temp_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= '0;
      psum_q <= '{default: '0};
      tsum_q <= '{default: '0};
      tcnt_q <= '{default: '0};
      full_q <= 1'b0;
      psum_o <= '{default: '0};
      tsum_o <= '{default: '0};
      tcnt_o <= '{default: '0};
      pcnt_o <= '0;
    end else begin
      if (full_q && tot_ready_i) begin
        full_q <= 1'b0;
      end
      if (in_valid_i && in_ready_o && tick) begin
        full_q <= 1'b1;
        psum_o <= psum_q;
        pcnt_o <= pcnt_q;
        tsum_o <= tsum_q;
        tcnt_o <= tcnt_q;
        pcnt_q <= '0;
        psum_q <= '{default: '0};
        tsum_q <= '{default: '0};
        tcnt_q <= '{default: '0};
      end else if (acc_ok) begin
        pcnt_q    <= pcnt_q + 1'b1;
        psum_q[0] <= psum_q[0] + PSumW'(in_data_i.pressure_a);
        psum_q[1] <= psum_q[1] + PSumW'(in_data_i.pressure_b);
        for (int c = 0; c < 3; c++) begin
          if (tv[c]) begin
            tsum_q[c] <= tsum_q[c] + TSumW'(tin[c]);
            tcnt_q[c] <= tcnt_q[c] + 1'b1;
          end
        end
      end
    end
  end

  assign tot_valid_o = full_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pcnt_q) <= MaxSamples) else $error("sample count overrun");
  a_tcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tcnt_q[0] <= pcnt_q && tcnt_q[1] <= pcnt_q && tcnt_q[2] <= pcnt_q)
    else $error("temp count exceeds sample count");
  a_tick_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && tick |=> pcnt_q == '0 && full_q)
    else $error("tick did not clear period");
`endif

endmodule

FILE: rtl/bafl_back.sv
// Back end: divides totals, shifts history, and runs the FIR per channel.
module bafl_back
  import bafl_pkg::*;
#(
  parameter int unsigned Taps      = 5,
  parameter int unsigned CntW      = 9,
  parameter int unsigned PSumW     = 20,
  parameter int unsigned TSumW     = 25,
  parameter int unsigned FracBits  = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CoefW-1:0]         coef_i [NumCoef],
  input  logic                     tot_valid_i,
  output logic                     tot_ready_o,
  input  logic [PSumW-1:0]         psum_i [2],
  input  logic [CntW-1:0]          pcnt_i,
  input  logic signed [TSumW-1:0]  tsum_i [3],
  input  logic [CntW-1:0]          tcnt_i [3],
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output rsp_t                     out_data_o
);

  localparam int unsigned DW   = TSumW;
  localparam int unsigned DCW  = $clog2(DW + 1);
  localparam int unsigned TapW = (Taps > 1) ? $clog2(Taps) : 1;
  localparam int unsigned ProdW = TempW + CoefW + 1;
  localparam int unsigned AccW  = ProdW + TapW + 1;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StDiv  = 5'b00010,
    StPush = 5'b00100,
    StFir  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e                  state_q;
  logic [2:0]              ch_q;
  logic [DCW-1:0]          bit_q;
  logic [DW-1:0]           num_q;
  logic [CntW-1:0]         den_q;
  logic [DW-1:0]           quo_q;
  logic [CntW:0]           rem_q;
  logic                    neg_q;
  logic signed [TempW-1:0] avg_q [NumChan];
  logic signed [TempW-1:0] hist_q [Taps][NumChan];
  logic [TapW-1:0]         tap_q;
  logic signed [ProdW-1:0] prod_q;
  logic                    prod_v_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [TempW-1:0] res_q [NumChan];

  logic [PSumW-1:0]        psum_q [2];
  logic [CntW-1:0]         pcnt_q;
  logic signed [TSumW-1:0] tsum_q [3];
  logic [CntW-1:0]         tcnt_q [3];

  logic signed [DW:0]      sel_num;
  logic [CntW-1:0]         sel_den;
  logic [CntW:0]           rem_sh;
  logic [CoefW-1:0]        cur_coef;
  logic signed [TempW-1:0] cur_hist;
  logic signed [AccW-1:0]  sat_v;
  logic signed [TempW-1:0] sat_res;

  always_comb begin
    sel_num = '0;
    sel_den = '0;
    case (ch_q)
      3'd0: begin sel_num = (DW+1)'(psum_q[0]); sel_den = pcnt_q; end
      3'd1: begin sel_num = (DW+1)'(psum_q[1]); sel_den = pcnt_q; end
      3'd2: begin sel_num = (DW+1)'(tsum_q[0]); sel_den = tcnt_q[0]; end
      3'd3: begin sel_num = (DW+1)'(tsum_q[1]); sel_den = tcnt_q[1]; end
      3'd4: begin sel_num = (DW+1)'(tsum_q[2]); sel_den = tcnt_q[2]; end
      default: begin sel_num = '0; sel_den = '0; end
    endcase
  end

  assign rem_sh   = {rem_q[CntW-1:0], num_q[DW-1]};
  assign cur_coef = (32'(tap_q) < NumCoef) ? coef_i[tap_q] : '0;
  assign cur_hist = hist_q[tap_q][ch_q];

  always_comb begin
    sat_v = acc_q;
    if (ch_q < 3'd2) begin
      if (acc_q < 0) sat_v = '0;
      else if (acc_q > AccW'(4095)) sat_v = AccW'(4095);
    end else begin
      if (acc_q < -AccW'(32768)) sat_v = -AccW'(32768);
      else if (acc_q > AccW'(32767)) sat_v = AccW'(32767);
    end
    sat_res = sat_v[TempW-1:0];
  end

  assign tot_ready_o = state_q == StIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ch_q     <= '0;
      bit_q    <= '0;
      tap_q    <= '0;
      prod_v_q <= 1'b0;
      hist_q   <= '{default: '{default: '0}};
    end else begin
      unique case (state_q)
        StIdle: begin
          if (tot_valid_i) begin
            psum_q  <= psum_i;
            pcnt_q  <= pcnt_i;
            tsum_q  <= tsum_i;
            tcnt_q  <= tcnt_i;
            ch_q    <= '0;
            bit_q   <= '0;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (bit_q == '0) begin
            neg_q <= sel_num[DW];
            num_q <= sel_num[DW] ? DW'(-sel_num) : sel_num[DW-1:0];
            den_q <= sel_den;
            rem_q <= '0;
            quo_q <= '0;
            bit_q <= DCW'(1);
          end else if (32'(bit_q) <= DW) begin
            if (rem_sh >= {1'b0, den_q}) begin
              rem_q <= rem_sh - {1'b0, den_q};
              quo_q <= {quo_q[DW-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              quo_q <= {quo_q[DW-2:0], 1'b0};
            end
            num_q <= {num_q[DW-2:0], 1'b0};
            bit_q <= bit_q + 1'b1;
          end else begin
            if (den_q == '0) avg_q[ch_q] <= '0;
            else avg_q[ch_q] <= neg_q ? TempW'(-quo_q) : quo_q[TempW-1:0];
            bit_q <= '0;
            if (ch_q == 3'(NumChan - 1)) begin
              ch_q    <= '0;
              state_q <= StPush;
            end else begin
              ch_q <= ch_q + 1'b1;
            end
          end
        end
        StPush: begin
          for (int i = Taps - 1; i > 0; i--) hist_q[i] <= hist_q[i-1];
          hist_q[0] <= avg_q;
          tap_q     <= '0;
          prod_v_q  <= 1'b0;
          acc_q     <= '0;
          state_q   <= StFir;
        end
        StFir: begin
          if (!prod_v_q) begin
            prod_q   <= ProdW'(cur_hist) * $signed({1'b0, cur_coef});
            prod_v_q <= 1'b1;
          end else begin
            acc_q    <= acc_q + AccW'(prod_q >>> FracBits);
            prod_v_q <= 1'b0;
            if (32'(tap_q) == Taps - 1) begin
              tap_q <= '0;
              state_q <= StOut;
            end else begin
              tap_q <= tap_q + 1'b1;
            end
          end
        end
        StOut: begin
          res_q[ch_q] <= sat_res;
          if (ch_q == 3'(NumChan - 1)) begin
            if (!out_valid_o || out_ready_i) begin
              acc_q   <= '0;
              ch_q    <= '0;
              state_q <= StIdle;
            end
          end else begin
            acc_q   <= '0;
            ch_q    <= ch_q + 1'b1;
            state_q <= StFir;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  logic out_v_q;
  logic fin;
  assign fin = state_q == StOut && ch_q == 3'(NumChan - 1) &&
               (!out_v_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fin) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_data_o.filt_pressure_a <= res_q[0][PresW-1:0];
      out_data_o.filt_pressure_b <= res_q[1][PresW-1:0];
      out_data_o.filt_temp_a     <= res_q[2];
      out_data_o.filt_temp_b     <= res_q[3];
      out_data_o.filt_temp_c     <= sat_res;
    end
  end

  assign out_valid_o = out_v_q;

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot_valid_i && tot_ready_o |=> state_q == StDiv)
    else $error("totals taken without starting division");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped");
  a_fin_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> state_q == StIdle)
    else $error("finish did not return to idle");
`endif

endmodule

FILE: rtl/block_average_fir_lowpass_core.sv
// Top level of the block-average FIR low-pass core.
// A sample transfer is accumulated into registered totals and the core takes
// a new one every cycle. A tick transfer closes the period: the totals move
// through a one-entry queue to the back end, which divides five channels one
// quotient bit per cycle and then runs the filter with one shared multiplier,
// one tap after another for each channel. Samples keep being accepted meanwhile;
// a second tick waits until the back end has taken the first one's totals.
module block_average_fir_lowpass_core
  import bafl_pkg::*;
#(
  parameter int unsigned MaxSamples   = 256,
  parameter int unsigned Taps         = 5,
  parameter int unsigned CoefFracBits = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  bafl_req_if.sink                req,
  bafl_rsp_if.source              rsp,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CoefW-1:0]        cfg_data_i
);

  localparam int unsigned CntW  = $clog2(MaxSamples + 1);
  localparam int unsigned PSumW = PresW + CntW;
  localparam int unsigned TSumW = TempW + CntW;

  logic [CoefW-1:0]        coef_q [NumCoef];
  logic                    tot_valid;
  logic                    tot_ready;
  logic [PSumW-1:0]        psum [2];
  logic [CntW-1:0]         pcnt;
  logic signed [TSumW-1:0] tsum [3];
  logic [CntW-1:0]         tcnt [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= CoefReset;
    end else if (cfg_we_i && 32'(cfg_idx_i) < NumCoef) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  bafl_front #(
    .MaxSamples(MaxSamples), .CntW(CntW), .PSumW(PSumW), .TSumW(TSumW)
  ) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .in_data_i  (req.data),
    .tot_valid_o(tot_valid),
    .tot_ready_i(tot_ready),
    .psum_o     (psum),
    .pcnt_o     (pcnt),
    .tsum_o     (tsum),
    .tcnt_o     (tcnt)
  );

  bafl_back #(
    .Taps(Taps), .CntW(CntW), .PSumW(PSumW), .TSumW(TSumW),
    .FracBits(CoefFracBits)
  ) u_back (
    .clk_i, .rst_ni,
    .coef_i     (coef_q),
    .tot_valid_i(tot_valid),
    .tot_ready_o(tot_ready),
    .psum_i     (psum),
    .pcnt_i     (pcnt),
    .tsum_i     (tsum),
    .tcnt_i     (tcnt),
    .out_valid_o(rsp.valid),
    .out_ready_i(rsp.ready),
    .out_data_o (rsp.data)
  );

endmodule

FILE: tb/sv/bafl_filter_checker.sv
// Checker that predicts the filtered period averages and compares them with the core's output.
module bafl_filter_checker
  import bafl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  bafl_req_if                req,
  bafl_rsp_if                rsp,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoefW-1:0]   cfg_data_i,
  output int                 mismatch_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PeriodCap = 256;
  localparam int unsigned NumTaps   = 5;
  localparam int unsigned FracBits  = 12;

  logic [CoefW-1:0]        coef_q    [NumCoef];
  logic [19:0]             pres_sum  [2];
  logic [8:0]              pres_cnt;
  logic signed [24:0]      temp_sum  [3];
  logic [8:0]              temp_cnt  [3];
  logic [PresW-1:0]        pres_hist [NumTaps][2];
  logic signed [TempW-1:0] temp_hist [NumTaps][3];
  rsp_t                    filt_queue [$];

  assign pending_o = filt_queue.size();

  function automatic longint fir_sum(input longint vals [NumTaps]);
    longint acc;
    acc = 0;
    for (int i = 0; i < NumTaps; i++) begin
      acc += (vals[i] * longint'(coef_q[i])) >>> FracBits;
    end
    return acc;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic clear_period();
    pres_sum = '{default: '0};
    pres_cnt = '0;
    temp_sum = '{default: '0};
    temp_cnt = '{default: '0};
  endtask

  task automatic close_period();
    rsp_t   expd;
    longint vals [NumTaps];
    longint outv [NumChan];
    for (int i = NumTaps - 1; i > 0; i--) begin
      pres_hist[i] = pres_hist[i-1];
      temp_hist[i] = temp_hist[i-1];
    end
    for (int c = 0; c < 2; c++) begin
      pres_hist[0][c] = (pres_cnt != 0) ? PresW'(pres_sum[c] / pres_cnt) : '0;
    end
    for (int c = 0; c < 3; c++) begin
      temp_hist[0][c] = (temp_cnt[c] != 0) ?
          TempW'(longint'(temp_sum[c]) / longint'(temp_cnt[c])) : '0;
    end
    clear_period();
    for (int c = 0; c < NumChan; c++) begin
      for (int i = 0; i < NumTaps; i++) begin
        vals[i] = (c < 2) ? longint'(pres_hist[i][c]) : longint'(temp_hist[i][c-2]);
      end
      outv[c] = (c < 2) ? clamp(fir_sum(vals), 0, 4095) : clamp(fir_sum(vals), -32768, 32767);
    end
    expd.filt_pressure_a = outv[0][PresW-1:0];
    expd.filt_pressure_b = outv[1][PresW-1:0];
    expd.filt_temp_a     = outv[2][TempW-1:0];
    expd.filt_temp_b     = outv[3][TempW-1:0];
    expd.filt_temp_c     = outv[4][TempW-1:0];
    filt_queue.push_back(expd);
  endtask

  task automatic take_sample(input req_t s);
    logic signed [TempW-1:0] t [3];
    logic                    v [3];
    if (pres_cnt >= PeriodCap) return;
    t = '{s.temp_a, s.temp_b, s.temp_c};
    v = '{s.valid_a, s.valid_b, s.valid_c};
    pres_sum[0] += s.pressure_a;
    pres_sum[1] += s.pressure_b;
    pres_cnt++;
    for (int c = 0; c < 3; c++) begin
      if (v[c]) begin
        temp_sum[c] += t[c];
        temp_cnt[c]++;
      end
    end
  endtask

  task automatic flag(input string what, input rsp_t expd, input rsp_t got);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) begin
      $display("%t %s: expected pa=%0d pb=%0d ta=%0d tb=%0d tc=%0d got pa=%0d pb=%0d ta=%0d tb=%0d tc=%0d",
               $realtime, what, expd.filt_pressure_a, expd.filt_pressure_b, expd.filt_temp_a,
               expd.filt_temp_b, expd.filt_temp_c, got.filt_pressure_a, got.filt_pressure_b,
               got.filt_temp_a, got.filt_temp_b, got.filt_temp_c);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t expd;
    if (!rst_ni) begin
      for (int i = 0; i < NumCoef; i++) coef_q[i] = CoefReset[i];
      clear_period();
      pres_hist = '{default: '{default: '0}};
      temp_hist = '{default: '{default: '0}};
      filt_queue.delete();
      mismatch_count_o = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (filt_queue.size() == 0) begin
          flag("unexpected transfer", '0, rsp.data);
        end else begin
          expd = filt_queue.pop_front();
          if (expd.filt_pressure_a !== rsp.data.filt_pressure_a ||
              expd.filt_pressure_b !== rsp.data.filt_pressure_b ||
              expd.filt_temp_a !== rsp.data.filt_temp_a ||
              expd.filt_temp_b !== rsp.data.filt_temp_b ||
              expd.filt_temp_c !== rsp.data.filt_temp_c) begin
            flag("mismatch", expd, rsp.data);
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req_type_e'(req.data.req_type) == ReqTick) close_period();
        else take_sample(req.data);
      end
      if (cfg_we_i && cfg_idx_i < NumCoef) coef_q[cfg_idx_i] = cfg_data_i;
    end
  end
endmodule

FILE: tb/sv/tb.sv
// Testbench top: drives periods of samples and ticks into the core and gives the verdict.
module tb;
  import bafl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 5000;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CoefW-1:0]   cfg_data;
  int                 mismatch_count;
  int                 pending;
  int                 tx_idle_pct;
  int                 rx_idle_pct;
  int                 item_count;
  int                 quiet_cycles;

  bafl_req_if req_ch ();
  bafl_rsp_if rsp_ch ();

  block_average_fir_lowpass_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  bafl_filter_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .req              (req_ch),
    .rsp              (rsp_ch),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_t sample(input logic [PresW-1:0] pa, input logic [PresW-1:0] pb,
                                  input logic [TempW-1:0] ta, input logic [TempW-1:0] tb,
                                  input logic [TempW-1:0] tc, input logic [2:0] vld);
    req_t r;
    r.req_type   = ReqSample;
    r.pressure_a = pa;
    r.pressure_b = pb;
    r.temp_a     = ta;
    r.temp_b     = tb;
    r.temp_c     = tc;
    {r.valid_a, r.valid_b, r.valid_c} = vld;
    return r;
  endfunction

  function automatic req_t rand_item(input logic tick);
    req_t r;
    r = sample(PresW'($urandom_range(0, 4095)), PresW'($urandom_range(0, 4095)),
               TempW'($urandom), TempW'($urandom), TempW'($urandom),
               3'($urandom_range(0, 7)));
    r.req_type = tick ? ReqTick : ReqSample;
    return r;
  endfunction

  task automatic push_item(input req_t item);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= item;
    @(posedge clk iff (req_ch.valid && req_ch.ready));
    item_count++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_coef(input int idx, input int val);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgIdxW'(idx);
    cfg_data <= CoefW'(val);
    @(posedge clk);
  endtask

  task automatic random_periods(input int target);
    int len;
    while (item_count < target) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 12);
      repeat (len) push_item(($urandom_range(0, 29) == 0) ? rand_item(1'b1) : rand_item(1'b0));
      push_item(rand_item(1'b1));
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    tx_idle_pct = 22;
    rx_idle_pct = 88;
    item_count = 0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_item(rand_item(1'b1));
    push_item(sample(12'hfff, 12'hfff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 3'b111));
    push_item(sample(12'hfff, 12'hfff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 3'b111));
    push_item(rand_item(1'b1));
    push_item(sample(12'h000, 12'h000, 16'sh8000, 16'sh8000, 16'sh8000, 3'b111));
    push_item(sample(12'h000, 12'h001, 16'sh8000, 16'sh8000, 16'sh8000, 3'b111));
    push_item(rand_item(1'b1));
    push_item(sample(12'h001, 12'h002, -16'sd3, 16'sd3, 16'sh1234, 3'b110));
    push_item(sample(12'h002, 12'h002, 16'sd0, 16'sd0, -16'sd5, 3'b110));
    push_item(sample(12'h7ff, 12'h800, 16'sh7fff, 16'sh8000, 16'sh5555, 3'b000));
    push_item(rand_item(1'b1));
    push_item(sample(12'h800, 12'h7ff, -16'sd7, 16'sd7, -16'sd1, 3'b111));
    push_item(sample(12'h800, 12'h7ff, -16'sd8, 16'sd8, 16'sd0, 3'b111));
    push_item(sample(12'h555, 12'haaa, 16'shaaaa, 16'sh5555, 16'sh0001, 3'b001));
    push_item(rand_item(1'b1));
    push_item(rand_item(1'b1));
    push_item(rand_item(1'b1));
    push_item(rand_item(1'b1));
    push_item(rand_item(1'b1));
    random_periods(425);
    drain();

    for (int i = 0; i < NumCoef; i++) write_coef(i, 4096);
    write_coef(5, 0);
    write_coef(6, 0);
    write_coef(7, 0);
    cfg_we <= 1'b0;
    random_periods(850);
    drain();

    tx_idle_pct = 88;
    rx_idle_pct = 22;
    for (int i = 0; i < NumCoef; i++) write_coef(i, 0);
    cfg_we <= 1'b0;
    random_periods(1000);
    drain();
    write_coef(0, 4096);
    write_coef(2, 8191);
    cfg_we <= 1'b0;
    random_periods(1150);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < NumCoef; i++) write_coef(i, $urandom_range(0, 4096));
    cfg_we <= 1'b0;
    random_periods(1450);
    drain();
    for (int i = 0; i < NumCoef; i++) write_coef(i, $urandom_range(0, 1500));
    cfg_we <= 1'b0;
    random_periods(1700);
    drain();
    repeat (200) @(posedge clk);

    if (mismatch_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
